[src/mau_pkg.sv]
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants for the Mish activation unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int          IFRAC         = 30;
    localparam logic [30:0] IONE          = 31'h4000_0000;
    localparam logic [24:0] LOG2E_Q24     = 25'd24204406;
    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam int          HORNER_TERMS  = 12;
    localparam int          EXP_LAT       = 3 + 3 * HORNER_TERMS;
    localparam int          DIV_LAT       = IFRAC + 1;
    localparam int          SIDE_LEN      = EXP_LAT + 2 * DIV_LAT + 6;

    typedef struct packed {
        logic               func;
        logic signed [15:0] x_in;
        logic signed [15:0] grad_in;
    } mau_in_t;

    typedef struct packed {
        logic signed [15:0] y_out;
        logic               saturated;
    } mau_out_t;

    typedef struct packed {
        logic        func;
        logic        xneg;
        logic [15:0] xmag;
        logic        gneg;
        logic [15:0] gmag;
    } mau_side_t;

endpackage

[src/mish_activation_unit.sv]
// ----------------------------------------------------------------------------
// mish_activation_unit
// Mish activation and its gradient in signed Q8.8, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_valid/s_ready/s_data (func, x_in, grad_in).
//   A forward item (func 0) yields mish(x_in). A backward item (func 1)
//   yields mish'(x_in) * grad_in while gradient_enable is set and nothing
//   while it is clear. Results leave on m_valid/m_ready/m_data with a
//   saturation flag.
//   gradient_enable must be written through cfg_we/cfg_wdata only while
//   idle; the block does not enforce it. Throughput: one item per cycle
//   unless the receiver stalls. The exponent series (39 stages) and two
//   chained bit-per-stage dividers (31 stages each) dominate the depth.
//   Reset clears all valid bits and sets gradient_enable to 1.
//   When the receiver stalls, the whole pipeline holds and s_ready drops
//   until the output register is taken.
// ----------------------------------------------------------------------------
module mish_activation_unit import mau_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output mau_out_t m_data,
    input  logic     cfg_we,
    input  logic     cfg_wdata
);

    localparam int IDX_P1  = EXP_LAT + 1;
    localparam int IDX_P2  = EXP_LAT + 2;
    localparam int IDX_D2  = IDX_P2 + 2 * DIV_LAT;
    localparam int IDX_F1  = IDX_D2 + 1;
    localparam int IDX_F2  = IDX_D2 + 2;

    logic        ge_reg;
    logic        en;
    logic        vld_reg  [0:SIDE_LEN-1];
    mau_side_t   side_reg [0:SIDE_LEN-1];
    mau_side_t   side_in;

    logic [30:0] e_val;
    logic [30:0] e_p1_reg;
    logic [30:0] e2_reg;
    logic [61:0] ee_prod;
    logic [30:0] mul_a;
    logic [62:0] m_prod;
    logic [32:0] num_reg;
    logic [32:0] den_reg;
    logic [32:0] m_reg;
    logic [32:0] num_c;
    logic [32:0] den_c;

    logic [30:0] t_q;
    logic [30:0] s1_q;
    logic [32:0] s1_d;
    logic [30:0] s2_q;
    logic [30:0] t_dly_reg [0:DIV_LAT-1];

    logic [46:0] xs_prod;
    logic [40:0] term_reg;
    logic [30:0] t_f1_reg;
    logic [41:0] dmag_reg;
    logic        dneg_reg;
    logic [41:0] dmag_c;
    logic        dneg_c;
    logic [57:0] prod_reg;
    logic        pneg_reg;
    logic [15:0] mul_x;

    logic [58:0] rnd;
    logic [28:0] rmag;
    mau_out_t    res_c;
    logic        out_valid_reg;
    mau_out_t    out_data_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        side_in.func = s_data.func;
        side_in.xneg = s_data.x_in[15];
        side_in.xmag = s_data.x_in[15] ? 16'(-s_data.x_in) : 16'(s_data.x_in);
        side_in.gneg = s_data.grad_in[15];
        side_in.gmag = s_data.grad_in[15] ? 16'(-s_data.grad_in) : 16'(s_data.grad_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ge_reg <= 1'b1;
        end else if (cfg_we) begin
            ge_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SIDE_LEN; j++) begin
                vld_reg[j] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid && !(s_data.func && !ge_reg);
            for (int j = 1; j < SIDE_LEN; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
            out_valid_reg <= vld_reg[SIDE_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int j = 1; j < SIDE_LEN; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    mau_exp u_exp (
        .aclk   (aclk),
        .en     (en),
        .mag_in (side_reg[0].xmag),
        .e_out  (e_val)
    );

    assign ee_prod = 62'(e_val) * 62'(e_val);
    assign mul_a   = side_reg[IDX_P1].xneg ? e_p1_reg : e2_reg;
    assign m_prod  = 63'(mul_a) * 63'(32'(IONE) + 32'(e_p1_reg));

    always_comb begin
        if (!side_reg[IDX_P1].xneg) begin
            num_c = 33'(IONE) + 33'({e_p1_reg, 1'b0});
            den_c = num_c + 33'({e2_reg, 1'b0});
        end else begin
            num_c = 33'(e2_reg) + 33'({e_p1_reg, 1'b0});
            den_c = num_c + 33'({IONE, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_p1_reg <= e_val;
            e2_reg   <= ee_prod[60:30];
            num_reg  <= num_c;
            den_reg  <= den_c;
            m_reg    <= m_prod[62:30];
        end
    end

    mau_div u_div_t (
        .aclk    (aclk),
        .en      (en),
        .num_in  (num_reg),
        .den_in  (den_reg),
        .quo_out (t_q),
        .den_out ()
    );

    mau_div u_div_s1 (
        .aclk    (aclk),
        .en      (en),
        .num_in  (m_reg),
        .den_in  (den_reg),
        .quo_out (s1_q),
        .den_out (s1_d)
    );

    mau_div u_div_s2 (
        .aclk    (aclk),
        .en      (en),
        .num_in  (33'(s1_q)),
        .den_in  (s1_d),
        .quo_out (s2_q),
        .den_out ()
    );

    assign xs_prod = 47'(side_reg[IDX_D2].xmag) * 47'(s2_q);

    always_comb begin
        if (!side_reg[IDX_F1].func) begin
            dmag_c = 42'(t_f1_reg);
            dneg_c = side_reg[IDX_F1].xneg;
        end else if (!side_reg[IDX_F1].xneg) begin
            dmag_c = 42'(t_f1_reg) + 42'(term_reg);
            dneg_c = 1'b0;
        end else if (42'(term_reg) > 42'(t_f1_reg)) begin
            dmag_c = 42'(term_reg) - 42'(t_f1_reg);
            dneg_c = 1'b1;
        end else begin
            dmag_c = 42'(t_f1_reg) - 42'(term_reg);
            dneg_c = 1'b0;
        end
    end

    assign mul_x = side_reg[IDX_F2].func ? side_reg[IDX_F2].gmag : side_reg[IDX_F2].xmag;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_dly_reg[0] <= t_q;
            for (int j = 1; j < DIV_LAT; j++) begin
                t_dly_reg[j] <= t_dly_reg[j-1];
            end
            term_reg <= xs_prod[46:6];
            t_f1_reg <= t_dly_reg[DIV_LAT-1];
            dmag_reg <= dmag_c;
            dneg_reg <= dneg_c;
            prod_reg <= 58'(mul_x) * 58'(dmag_reg);
            pneg_reg <= side_reg[IDX_F2].func ? (dneg_reg ^ side_reg[IDX_F2].gneg) : dneg_reg;
        end
    end

    assign rnd  = 59'(prod_reg) + (59'd1 << (IFRAC - 1));
    assign rmag = rnd[58:30];

    always_comb begin
        if (pneg_reg) begin
            if (rmag > 29'd32768) begin
                res_c.y_out     = 16'sh8000;
                res_c.saturated = 1'b1;
            end else begin
                res_c.y_out     = 16'(29'd0 - rmag);
                res_c.saturated = 1'b0;
            end
        end else begin
            if (rmag > 29'd32767) begin
                res_c.y_out     = 16'sh7fff;
                res_c.saturated = 1'b1;
            end else begin
                res_c.y_out     = rmag[15:0];
                res_c.saturated = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= res_c;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[src/mau_exp.sv]
// ----------------------------------------------------------------------------
// mau_exp
// Pipelined e^-|x| in Q30: range split, then a Horner series, one step
// per three stages.
// ----------------------------------------------------------------------------
module mau_exp import mau_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] mag_in,
    output logic [30:0] e_out
);

    localparam int NST = 3 * HORNER_TERMS;

    logic [37:0] z_prod;
    logic        zero_reg;
    logic [5:0]  k_reg;
    logic [29:0] f_reg;
    logic [59:0] fg_prod;

    logic [29:0] g_pipe [0:NST];
    logic [5:0]  k_pipe [0:NST];
    logic        z_pipe [0:NST];

    logic [29:0] p_reg  [0:HORNER_TERMS-1];
    logic [29:0] p2_reg [0:HORNER_TERMS-1];
    logic [29:0] qh_reg [0:HORNER_TERMS-1];
    logic [30:0] r_reg  [1:HORNER_TERMS];
    logic [30:0] e_reg;

    assign z_prod  = 38'(mag_in[12:0]) * 38'(LOG2E_Q24);
    assign fg_prod = 60'(f_reg) * 60'(LN2_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg  <= |mag_in[15:13];
            k_reg     <= z_prod[37:32];
            f_reg     <= z_prod[31:2];
            g_pipe[0] <= fg_prod[59:30];
            k_pipe[0] <= k_reg;
            z_pipe[0] <= zero_reg;
            for (int j = 0; j < NST; j++) begin
                g_pipe[j+1] <= g_pipe[j];
                k_pipe[j+1] <= k_pipe[j];
                z_pipe[j+1] <= z_pipe[j];
            end
            e_reg <= z_pipe[NST] ? 31'd0 : (r_reg[HORNER_TERMS] >> k_pipe[NST]);
        end
    end

    for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_step
        localparam int          DIVN = HORNER_TERMS - i;
        localparam logic [34:0] RCP  = 35'((64'd1 << 34) / DIVN);
        logic [30:0] r_in;
        logic [60:0] gr;
        logic [64:0] pq;
        logic [33:0] rem;
        logic [29:0] q;

        if (i == 0) begin : g_first
            assign r_in = IONE;
        end else begin : g_rest
            assign r_in = r_reg[i];
        end

        assign gr  = 61'(g_pipe[3*i]) * 61'(r_in);
        assign pq  = 65'(p_reg[i]) * 65'(RCP);
        assign rem = 34'(p2_reg[i]) - 34'(qh_reg[i]) * 34'(DIVN);
        assign q   = (rem >= 34'(DIVN)) ? qh_reg[i] + 30'd1 : qh_reg[i];

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[i]    <= gr[59:30];
                qh_reg[i]   <= pq[63:34];
                p2_reg[i]   <= p_reg[i];
                r_reg[i+1]  <= IONE - 31'(q);
            end
        end
    end

    assign e_out = e_reg;

endmodule

[src/mau_div.sv]
// ----------------------------------------------------------------------------
// mau_div
// Pipelined restoring divider: floor((num << 30) / den), one bit per stage.
// ----------------------------------------------------------------------------
module mau_div import mau_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [32:0] num_in,
    input  logic [32:0] den_in,
    output logic [30:0] quo_out,
    output logic [32:0] den_out
);

    logic [32:0] rem_reg [0:DIV_LAT-1];
    logic [30:0] quo_reg [0:DIV_LAT-1];
    logic [32:0] den_reg [0:DIV_LAT-1];

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_bit
        logic [33:0] cand;
        logic [32:0] d;
        logic [30:0] qprev;
        logic        ge;

        if (j == 0) begin : g_first
            assign cand  = {1'b0, num_in};
            assign d     = den_in;
            assign qprev = '0;
        end else begin : g_rest
            assign cand  = {rem_reg[j-1], 1'b0};
            assign d     = den_reg[j-1];
            assign qprev = quo_reg[j-1];
        end

        assign ge = cand >= {1'b0, d};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? 33'(cand - {1'b0, d}) : cand[32:0];
                quo_reg[j] <= {qprev[29:0], ge};
                den_reg[j] <= d;
            end
        end
    end

    assign quo_out = quo_reg[DIV_LAT-1];
    assign den_out = den_reg[DIV_LAT-1];

endmodule
